>>> src/mi3_pkg.sv
`default_nettype none
package mi3_pkg;
  localparam int ELEMENT_BITS = 16;
  localparam int EW = 16;
  localparam int AW = 33;
  localparam int DW = 49;
  localparam int QDEPTH = 2;

  typedef struct packed {
    logic signed [EW-1:0] m0, m1, m2, m3, m4, m5, m6, m7, m8;
  } mat_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ADJ, ST_DET, ST_DIV, ST_EMIT
  } back_st_t;
endpackage
`default_nettype wire

>>> src/matrix_inverse_3x3_unit.sv
`default_nettype none
// channel | ports                              | handshake
// in      | in_element[15:0]                   | in_push / in_full
// out     | out_row..out_last                  | out_pop / out_empty
// Front loads one element per cycle when not full; a 2-deep matrix
// queue decouples it. Back: take, adjugate, determinant (shared
// multipliers), restoring division per entry (zero quotients if
// singular), then 9 words out.
// Reset (rst_n low, synchronous) empties queue and clears counters.
// Front stalls only when both queue slots hold matrices.
module matrix_inverse_3x3_unit import mi3_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire logic signed [EW-1:0] in_element,
  output logic                      out_empty,
  input  wire logic                 out_pop,
  output logic [1:0]                out_row,
  output logic [1:0]                out_column,
  output logic signed [AW-1:0]      out_adjugate_entry,
  output logic signed [AW-1:0]      out_quotient,
  output logic signed [DW-1:0]      out_determinant,
  output logic                      out_singular,
  output logic                      out_last
);
  logic mat_valid, mat_take;
  mat_t mat;

  mi3_front u_front (
    .clk, .rst_n, .push(in_push), .full(in_full), .element(in_element),
    .mat_valid, .mat, .mat_take
  );

  mi3_back u_back (
    .clk, .rst_n, .mat_valid, .mat, .mat_take,
    .empty(out_empty), .pop(out_pop), .row(out_row), .column(out_column),
    .adjugate_entry(out_adjugate_entry), .quotient(out_quotient),
    .determinant(out_determinant), .singular(out_singular), .last(out_last)
  );
endmodule
`default_nettype wire

>>> src/mi3_front.sv
`default_nettype none
module mi3_front import mi3_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic signed [EW-1:0] element,
  output logic                      mat_valid,
  output mat_t                      mat,
  input  wire logic                 mat_take
);
  logic [3:0] load_count_r;
  logic signed [EW-1:0] store_r [9];
  mat_t q_r [QDEPTH];
  logic [QDEPTH-1:0] qv_r;
  logic wr_ptr_r, rd_ptr_r;
  logic acc, done;
  logic signed [EW-1:0] sx;
  mat_t cur;

  assign sx = EW'($signed(element[ELEMENT_BITS-1:0]));
  assign full = qv_r[wr_ptr_r];
  assign acc = push && !full;
  assign done = acc && (load_count_r == 4'd8);
  assign mat_valid = qv_r[rd_ptr_r];
  assign mat = q_r[rd_ptr_r];

  always_comb begin
    cur = '{store_r[0], store_r[1], store_r[2], store_r[3], store_r[4],
            store_r[5], store_r[6], store_r[7], sx};
  end

  always_ff @(posedge clk) begin
    if (acc) store_r[load_count_r] <= sx;
    if (done) q_r[wr_ptr_r] <= cur;
    if (!rst_n) begin
      load_count_r <= '0;
      qv_r <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      if (acc) load_count_r <= done ? 4'd0 : load_count_r + 4'd1;
      if (done) begin
        qv_r[wr_ptr_r] <= 1'b1;
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (mat_take && mat_valid) begin
        qv_r[rd_ptr_r] <= 1'b0;
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) load_count_r <= 4'd8)
    else $error("load count overflow");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> mat_valid) else $error("queue lost matrix");
  a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (qv_r == '0) |-> (wr_ptr_r == rd_ptr_r)) else $error("pointer mismatch");
endmodule
`default_nettype wire

>>> src/mi3_back.sv
`default_nettype none
module mi3_back import mi3_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           mat_valid,
  input  mat_t                mat,
  output logic                mat_take,
  output logic                empty,
  input  wire logic           pop,
  output logic [1:0]          row,
  output logic [1:0]          column,
  output logic signed [AW-1:0] adjugate_entry,
  output logic signed [AW-1:0] quotient,
  output logic signed [DW-1:0] determinant,
  output logic                singular,
  output logic                last
);
  back_st_t st_r, st_nxt;
  logic signed [EW-1:0] m_r [9];
  logic signed [AW-1:0] adj_r [9];
  logic signed [DW-1:0] det_r;
  logic [3:0] idx_r;
  logic [1:0] ph_r;
  logic signed [AW-1:0] p0_r;
  logic signed [DW-1:0] acc_r;
  logic [AW-1:0] qmag_r;
  logic [DW-1:0] rem_r;
  logic [5:0] bit_r;
  logic signed [AW-1:0] qout_r [9];
  logic signed [2*EW-1:0] pa, pb;
  logic signed [DW-1:0] pc;
  logic [3:0] i0, i1, i2, i3, i4;
  logic [1:0] dc;
  logic [DW-1:0] dmag, rsh;
  logic [DW:0] diff;
  logic [AW-1:0] amag;
  logic neg;
  logic signed [AW-1:0] adj_cur;

  // (a + k) mod 3 for a, k in 0..2
  function automatic logic [1:0] nx(input logic [1:0] a, input logic [1:0] k);
    logic [2:0] s;
    s = {1'b0, a} + {1'b0, k};
    return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
  endfunction

  function automatic logic [3:0] ix(input logic [1:0] r, input logic [1:0] c);
    return {1'b0, r, 1'b0} + {2'b00, r} + {2'b00, c};
  endfunction

  assign dc = idx_r[1:0];

  always_comb begin
    i0 = ix(nx(column, 2'd1), nx(row, 2'd1));
    i1 = ix(nx(column, 2'd2), nx(row, 2'd2));
    i2 = ix(nx(column, 2'd2), nx(row, 2'd1));
    i3 = ix(nx(column, 2'd1), nx(row, 2'd2));
    if (st_r == ST_DET) begin
      i0 = ix(2'd1, nx(dc, 2'd1)); i1 = ix(2'd2, nx(dc, 2'd2));
      i2 = ix(2'd1, nx(dc, 2'd1)); i3 = ix(2'd2, dc);
    end
    i4 = (ph_r == 2'd1) ? ix(2'd0, dc) : ix(2'd0, nx(dc, 2'd2));
  end

  assign pa = m_r[i0] * m_r[i1];
  assign pb = m_r[i2] * m_r[i3];
  assign pc = DW'(p0_r) * DW'(m_r[i4]);

  assign adj_cur = adj_r[idx_r];
  assign neg = adj_cur[AW-1] ^ det_r[DW-1];
  assign amag = adj_cur[AW-1] ? AW'(-adj_cur) : adj_cur;
  assign dmag = det_r[DW-1] ? DW'(-det_r) : det_r;
  assign rsh = {rem_r[DW-2:0], amag[bit_r[5:0]]};
  assign diff = {1'b0, rsh} - {1'b0, dmag};

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (mat_valid) st_nxt = ST_ADJ;
      ST_ADJ:  if (idx_r == 4'd8) st_nxt = ST_DET;
      ST_DET:  if (idx_r == 4'd2 && ph_r == 2'd2) st_nxt = ST_DIV;
      ST_DIV:  if (idx_r == 4'd8 && (bit_r == 6'd0 || det_r == '0)) st_nxt = ST_EMIT;
      ST_EMIT: if (pop && idx_r == 4'd8) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mat_take = (st_r == ST_IDLE) && mat_valid;
    empty = (st_r != ST_EMIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      idx_r <= '0;
      ph_r <= '0;
    end else begin
      st_r <= st_nxt;
      unique case (st_r)
        ST_IDLE: begin
          idx_r <= '0;
          m_r <= '{mat.m0, mat.m1, mat.m2, mat.m3, mat.m4, mat.m5, mat.m6, mat.m7, mat.m8};
          acc_r <= '0; ph_r <= '0;
        end
        ST_ADJ: begin
          adj_r[idx_r] <= AW'(pa) - AW'(pb);
          idx_r <= (idx_r == 4'd8) ? 4'd0 : idx_r + 4'd1;
        end
        ST_DET: begin
          if (ph_r == 2'd0) begin
            p0_r <= AW'(pa); ph_r <= 2'd1;
          end else if (ph_r == 2'd1) begin
            acc_r <= acc_r + pc; p0_r <= AW'(pb); ph_r <= 2'd2;
          end else begin
            ph_r <= 2'd0;
            if (idx_r == 4'd2) begin
              det_r <= acc_r - pc; idx_r <= 4'd0;
              bit_r <= 6'(AW - 1); rem_r <= '0; qmag_r <= '0;
            end else begin
              acc_r <= acc_r - pc; idx_r <= idx_r + 4'd1;
            end
          end
        end
        ST_DIV: begin
          if (bit_r == 6'd0 || det_r == '0) begin
            if (det_r == '0) qout_r[idx_r] <= '0;
            else begin
              qout_r[idx_r] <= neg ? AW'(-{qmag_r[AW-2:0], ~diff[DW]})
                                   : AW'({qmag_r[AW-2:0], ~diff[DW]});
            end
            idx_r <= (idx_r == 4'd8) ? 4'd0 : idx_r + 4'd1;
            bit_r <= 6'(AW - 1); rem_r <= '0; qmag_r <= '0;
          end else begin
            rem_r <= diff[DW] ? rsh : diff[DW-1:0];
            qmag_r <= {qmag_r[AW-2:0], ~diff[DW]};
            bit_r <= bit_r - 6'd1;
          end
        end
        ST_EMIT: if (pop) idx_r <= (idx_r == 4'd8) ? 4'd0 : idx_r + 4'd1;
        default: ;
      endcase
    end
  end

  assign row = (idx_r >= 4'd6) ? 2'd2 : (idx_r >= 4'd3) ? 2'd1 : 2'd0;
  assign column = 2'(idx_r - 4'(row) * 4'd3);
  assign adjugate_entry = adj_r[idx_r];
  assign quotient = qout_r[idx_r];
  assign determinant = det_r;
  assign singular = (det_r == '0);
  assign last = (idx_r == 4'd8);

  a_idx: assert property (@(posedge clk) disable iff (!rst_n) idx_r <= 4'd8)
    else $error("index out of range");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    mat_take |=> st_r == ST_ADJ) else $error("take without start");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && last) |=> empty) else $error("emit past last");
endmodule
`default_nettype wire

>>> test/matrix_inverse_3x3_unit_checker.sv
module matrix_inverse_3x3_unit_checker import mi3_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  logic                 in_full,
  input  logic signed [EW-1:0] in_element,
  input  logic                 out_empty,
  input  logic                 out_pop,
  input  logic [1:0]           out_row,
  input  logic [1:0]           out_column,
  input  logic signed [AW-1:0] out_adjugate_entry,
  input  logic signed [AW-1:0] out_quotient,
  input  logic signed [DW-1:0] out_determinant,
  input  logic                 out_singular,
  input  logic                 out_last,
  output int                   errors,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]           row;
    logic [1:0]           column;
    logic signed [AW-1:0] adj;
    logic signed [AW-1:0] quo;
    logic signed [DW-1:0] det;
    logic                 sing;
    logic                 last;
  } inv_word_t;

  inv_word_t inverse_q[$];
  longint mat[9];
  int load_cnt;

  assign pending = inverse_q.size();

  function automatic longint at(int r, int c);
    return mat[(r % 3) * 3 + (c % 3)];
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task automatic predict_inverse();
    longint plus, minus, det, adj;
    inv_word_t w;
    plus = 0;
    minus = 0;
    for (int c = 0; c < 3; c++) begin
      plus += at(0, c) * at(1, c + 1) * at(2, c + 2);
      minus += at(0, c + 2) * at(1, c + 1) * at(2, c);
    end
    det = plus - minus;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        adj = at(c + 1, r + 1) * at(c + 2, r + 2) - at(c + 2, r + 1) * at(c + 1, r + 2);
        w.row = r[1:0];
        w.column = c[1:0];
        w.adj = adj[AW-1:0];
        w.quo = (det == 0) ? '0 : AW'(adj / det);
        w.det = det[DW-1:0];
        w.sing = (det == 0);
        w.last = (r == 2 && c == 2);
        inverse_q.push_back(w);
      end
    end
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    inv_word_t e;
    if (!rst_n) begin
      load_cnt <= 0;
    end else begin
      if (in_push && !in_full) begin
        mat[load_cnt] = longint'(in_element);
        if (load_cnt == 8) begin
          load_cnt <= 0;
          predict_inverse();
        end else begin
          load_cnt <= load_cnt + 1;
        end
      end
      if (out_pop && !out_empty) begin
        if (inverse_q.size() == 0) begin
          report("unexpected word", 1, 0);
        end else begin
          e = inverse_q.pop_front();
          if (out_row !== e.row) report("row", out_row, e.row);
          if (out_column !== e.column) report("column", out_column, e.column);
          if (out_adjugate_entry !== e.adj) report("adjugate", out_adjugate_entry, e.adj);
          if (out_quotient !== e.quo) report("quotient", out_quotient, e.quo);
          if (out_determinant !== e.det) report("determinant", out_determinant, e.det);
          if (out_singular !== e.sing) report("singular", out_singular, e.sing);
          if (out_last !== e.last) report("last", out_last, e.last);
        end
      end
    end
  end
endmodule

>>> test/matrix_inverse_3x3_unit_test.sv
module matrix_inverse_3x3_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mi3_pkg::*;

  logic                 clk = 0;
  logic                 rst_n = 0;
  logic                 in_push = 0;
  logic                 in_full;
  logic signed [EW-1:0] in_element = '0;
  logic                 out_empty;
  logic                 out_pop = 0;
  logic [1:0]           out_row, out_column;
  logic signed [AW-1:0] out_adjugate_entry, out_quotient;
  logic signed [DW-1:0] out_determinant;
  logic                 out_singular, out_last;
  int                   errors, pending;
  longint               cycles = 0;
  bit                   stim_done = 0;
  bit                   pop_quiet = 0;

  localparam longint CYCLE_LIMIT = 400000;
  localparam logic signed [EW-1:0] MAXV = 16'sh7fff;
  localparam logic signed [EW-1:0] MINV = 16'sh8000;

  always #5 clk = ~clk;

  matrix_inverse_3x3_unit dut (.*);

  matrix_inverse_3x3_unit_checker chk (.*);

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [EW-1:0] rand_element();
    int p;
    p = $urandom_range(0, 9);
    case (p)
      0: return MAXV;
      1: return MINV;
      2, 3: return EW'($signed($urandom_range(0, 8)) - 4);
      default: return EW'($urandom);
    endcase
  endfunction

  task automatic push_word(logic signed [EW-1:0] v);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_push <= 0;
      repeat (g) @(posedge clk);
    end
    in_push <= 1;
    in_element <= v;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic push_matrix(logic signed [EW-1:0] m[9]);
    for (int k = 0; k < 9; k++) push_word(m[k]);
  endtask

  always @(posedge clk) begin
    int g;
    if (rst_n) begin
      if (pop_quiet) begin
        out_pop <= 1;
      end else if ($urandom_range(0, 9) < 6) begin
        out_pop <= 1;
      end else begin
        out_pop <= 0;
        g = gap_len();
        if (g > 5) begin
          repeat (g) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout");
      $display("matrix_inverse_3x3_unit_test: FAIL");
      $finish;
    end
  end

  initial begin
    logic signed [EW-1:0] m[9];
    int tail;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // identity
    m = '{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1};
    push_matrix(m);
    // singular: all extreme negative
    foreach (m[k]) m[k] = MINV;
    push_matrix(m);
    // extremes mixed, nonsingular-ish
    m = '{MAXV, MINV, 16'sd0, MINV, MAXV, MINV, 16'sd0, MINV, MAXV};
    push_matrix(m);
    pop_quiet = 1;
    for (int n = 0; n < 20; n++) begin
      for (int k = 0; k < 9; k++) m[k] = rand_element();
      if (n % 8 == 3) begin
        for (int k = 0; k < 3; k++) m[6 + k] = m[3 + k];
      end
      pop_quiet = (n % 6 == 5);
      push_matrix(m);
    end
    in_push <= 0;
    pop_quiet = 0;
    stim_done = 1;
    while (pending != 0) @(posedge clk);
    tail = 0;
    while (tail < 400) begin
      @(posedge clk);
      tail++;
    end
    if (errors == 0 && pending == 0) begin
      $display("matrix_inverse_3x3_unit_test: PASS");
    end else begin
      $display("matrix_inverse_3x3_unit_test: FAIL");
    end
    $finish;
  end
endmodule
